// File: rtl/core/nafmt_pkg.sv
// package for the number to ascii formatter: op codes, states, helper functions
package nafmt_pkg;

  localparam int DecimalDigitsDefault = 5;

  typedef enum logic [2:0] {
    OpDecimal = 3'd0,
    OpHexByte = 3'd1,
    OpHexWord = 3'd2,
    OpBinByte = 3'd3,
    OpCrLf    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StEmit
  } state_e;

  localparam logic [7:0] ChZero = 8'd48;
  localparam logic [7:0] ChOne  = 8'd49;
  localparam logic [7:0] ChCr   = 8'd13;
  localparam logic [7:0] ChLf   = 8'd10;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = {4'b0000, nib} + 8'd48;
    end else begin
      r = {4'b0000, nib} + 8'd55;
    end
    return r;
  endfunction

  // largest value of the given number of decimal digits, clipped to 16 bits
  function automatic logic [15:0] dec_limit(input int digits);
    int p;
    p = 1;
    for (int i = 0; i < 5; i++) begin
      if (i < digits) begin
        p = p * 10;
      end
    end
    if (digits >= 5) begin
      return 16'hFFFF;
    end
    return 16'(p - 1);
  endfunction

endpackage

// File: rtl/core/number_to_ascii_formatter.sv
// number to ascii formatter: one request in, a run of ascii characters out
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | operation_i, value_i
//  out     | output    | out_valid_o/out_stall_i | character_o, last_o
//
// one request at a time; in_stall_o is low only while idle
// decimal: bit-serial shift-add-3 conversion of 16 bits, then one digit position
//   (DECIMAL_DIGITS) per cycle unless stalled; leading zero positions emit nothing
// hex and binary: one character per unstalled cycle from a 16-bit shift register
// a stalled output register holds the next step; reset clears control state only
module number_to_ascii_formatter #(
  parameter int DECIMAL_DIGITS = nafmt_pkg::DecimalDigitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [15:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  character_o,
  output logic        last_o
);

  localparam int BcdW = 4 * DECIMAL_DIGITS;
  localparam int CntMax = (DECIMAL_DIGITS > 16) ? DECIMAL_DIGITS : 16;
  localparam int CntW = $clog2(CntMax + 1);
  localparam logic [15:0] DecLimit = nafmt_pkg::dec_limit(DECIMAL_DIGITS);

  nafmt_pkg::state_e state_q, state_d;
  nafmt_pkg::op_e    op_q, op_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [15:0]       val_q, val_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic              started_q, started_d;
  logic              ovalid_q, ovalid_d;
  logic [7:0]        ochar_q, ochar_d;
  logic              olast_q, olast_d;

  logic              accept;
  logic              adv;
  logic              cnt_one;
  logic [3:0]        top_dig;
  logic [BcdW-1:0]   bcd_adj;

  assign in_stall_o  = (state_q != nafmt_pkg::StIdle);
  assign accept      = in_valid_i && !in_stall_o;
  assign adv         = (state_q == nafmt_pkg::StEmit) && (!ovalid_q || !out_stall_i);
  assign cnt_one     = (cnt_q == CntW'(1));
  assign top_dig     = bcd_q[BcdW-1 -: 4];
  assign out_valid_o = ovalid_q;
  assign character_o = ochar_q;
  assign last_o      = olast_q;

  // add three to every digit of five or more
  always_comb begin
    for (int i = 0; i < DECIMAL_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    cnt_d     = cnt_q;
    val_d     = val_q;
    bcd_d     = bcd_q;
    started_d = started_q;
    ovalid_d  = ovalid_q;
    ochar_d   = ochar_q;
    olast_d   = olast_q;

    if (ovalid_q && !out_stall_i) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      nafmt_pkg::StIdle: begin
        if (accept) begin
          started_d = 1'b0;
          bcd_d     = '0;
          unique case (operation_i)
            nafmt_pkg::OpDecimal: begin
              op_d    = nafmt_pkg::OpDecimal;
              val_d   = (value_i > DecLimit) ? DecLimit : value_i;
              cnt_d   = CntW'(16);
              state_d = nafmt_pkg::StConv;
            end
            nafmt_pkg::OpHexByte: begin
              op_d    = nafmt_pkg::OpHexByte;
              val_d   = {value_i[7:0], 8'h00};
              cnt_d   = CntW'(2);
              state_d = nafmt_pkg::StEmit;
            end
            nafmt_pkg::OpHexWord: begin
              op_d    = nafmt_pkg::OpHexWord;
              val_d   = value_i;
              cnt_d   = CntW'(4);
              state_d = nafmt_pkg::StEmit;
            end
            nafmt_pkg::OpBinByte: begin
              op_d    = nafmt_pkg::OpBinByte;
              val_d   = {value_i[7:0], 8'h00};
              cnt_d   = CntW'(8);
              state_d = nafmt_pkg::StEmit;
            end
            nafmt_pkg::OpCrLf: begin
              op_d    = nafmt_pkg::OpCrLf;
              cnt_d   = CntW'(2);
              state_d = nafmt_pkg::StEmit;
            end
            default: begin
              state_d = nafmt_pkg::StIdle;
            end
          endcase
        end
      end
      nafmt_pkg::StConv: begin
        bcd_d = {bcd_adj[BcdW-2:0], val_q[15]};
        val_d = {val_q[14:0], 1'b0};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_one) begin
          cnt_d   = CntW'(DECIMAL_DIGITS);
          state_d = nafmt_pkg::StEmit;
        end
      end
      nafmt_pkg::StEmit: begin
        if (adv) begin
          cnt_d = cnt_q - CntW'(1);
          unique case (op_q)
            nafmt_pkg::OpDecimal: begin
              bcd_d = bcd_q << 4;
              if (top_dig != 4'd0 || started_q || cnt_one) begin
                started_d = 1'b1;
                ovalid_d  = 1'b1;
                ochar_d   = nafmt_pkg::ChZero + {4'b0000, top_dig};
                olast_d   = cnt_one;
              end
            end
            nafmt_pkg::OpHexByte, nafmt_pkg::OpHexWord: begin
              val_d    = {val_q[11:0], 4'h0};
              ovalid_d = 1'b1;
              ochar_d  = nafmt_pkg::hex_char(val_q[15:12]);
              olast_d  = cnt_one;
            end
            nafmt_pkg::OpBinByte: begin
              val_d    = {val_q[14:0], 1'b0};
              ovalid_d = 1'b1;
              ochar_d  = val_q[15] ? nafmt_pkg::ChOne : nafmt_pkg::ChZero;
              olast_d  = cnt_one;
            end
            nafmt_pkg::OpCrLf: begin
              ovalid_d = 1'b1;
              ochar_d  = cnt_one ? nafmt_pkg::ChLf : nafmt_pkg::ChCr;
              olast_d  = cnt_one;
            end
            default: begin
              ovalid_d = ovalid_q;
            end
          endcase
          if (cnt_one) begin
            state_d = nafmt_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = nafmt_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nafmt_pkg::StIdle;
      ovalid_q  <= 1'b0;
      cnt_q     <= '0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ovalid_q  <= ovalid_d;
      cnt_q     <= cnt_d;
      started_q <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    val_q   <= val_d;
    bcd_q   <= bcd_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  a_conv_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nafmt_pkg::StConv && cnt_one) |=> (state_q == nafmt_pkg::StEmit))
    else $error("conversion did not hand over to emission");

  a_last_step_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && cnt_one) |=> (out_valid_o && last_o && state_q == nafmt_pkg::StIdle))
    else $error("final step did not present a marked character");

  a_bad_op_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i != nafmt_pkg::OpDecimal && operation_i != nafmt_pkg::OpHexByte
     && operation_i != nafmt_pkg::OpHexWord && operation_i != nafmt_pkg::OpBinByte
     && operation_i != nafmt_pkg::OpCrLf) |=> (state_q == nafmt_pkg::StIdle))
    else $error("undefined operation started a run");

endmodule

// File: verif/testbench.sv
// testbench for number_to_ascii_formatter: random and directed requests, per-character scoreboard
`timescale 1ns / 100ps

module testbench;

  localparam int          DecDigits     = nafmt_pkg::DecimalDigitsDefault;
  localparam logic [2:0]  OpUndefFirst  = 3'd5;
  localparam logic [2:0]  OpUndefMid    = 3'd6;
  localparam logic [2:0]  OpUndefLast   = 3'd7;
  localparam logic [7:0]  AlphaOffset   = 8'd55;
  localparam int          MaxReported   = 10;
  localparam int          TailCycles    = 64;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } ascii_char_t;

  class ascii_scoreboard;
    ascii_char_t expected_chars[$];
    int          errors;

    function logic [7:0] hex_digit(input logic [3:0] nib);
      return (nib < 4'd10) ? 8'(nib) + nafmt_pkg::ChZero : 8'(nib) + AlphaOffset;
    endfunction

    function void note_request(input logic [2:0] op, input logic [15:0] val);
      logic [7:0]       run[$];
      longint unsigned  v;
      longint unsigned  divider;
      longint unsigned  limit;
      longint unsigned  d;
      bit               started;
      ascii_char_t      item;
      started = 1'b0;
      case (op)
        nafmt_pkg::OpDecimal: begin
          divider = 1;
          for (int k = 1; k < DecDigits; k++) divider *= 10;
          limit = divider * 10 - 1;
          v = val;
          if (v > limit) v = limit;
          if (v == 0) begin
            run.push_back(nafmt_pkg::ChZero);
          end else begin
            for (int k = 0; k < DecDigits; k++) begin
              d = v / divider;
              if (d != 0 || started) begin
                started = 1'b1;
                run.push_back(8'(d) + nafmt_pkg::ChZero);
                v = v % divider;
              end
              divider /= 10;
            end
          end
        end
        nafmt_pkg::OpHexByte: begin
          run.push_back(hex_digit(val[7:4]));
          run.push_back(hex_digit(val[3:0]));
        end
        nafmt_pkg::OpHexWord: begin
          run.push_back(hex_digit(val[15:12]));
          run.push_back(hex_digit(val[11:8]));
          run.push_back(hex_digit(val[7:4]));
          run.push_back(hex_digit(val[3:0]));
        end
        nafmt_pkg::OpBinByte: begin
          for (int k = 7; k >= 0; k--) begin
            run.push_back(val[k] ? nafmt_pkg::ChOne : nafmt_pkg::ChZero);
          end
        end
        nafmt_pkg::OpCrLf: begin
          run.push_back(nafmt_pkg::ChCr);
          run.push_back(nafmt_pkg::ChLf);
        end
        default: ;
      endcase
      for (int i = 0; i < run.size(); i++) begin
        item.ch   = run[i];
        item.last = (i == run.size() - 1);
        expected_chars.push_back(item);
      end
    endfunction

    function void check_result(input logic [7:0] ch, input logic last);
      ascii_char_t exp_item;
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= MaxReported)
          $display("unexpected character 0x%02h last %0b", ch, last);
        return;
      end
      exp_item = expected_chars.pop_front();
      if (ch !== exp_item.ch || last !== exp_item.last) begin
        errors++;
        if (errors <= MaxReported)
          $display("mismatch: expected char 0x%02h last %0b, got char 0x%02h last %0b",
                   exp_item.ch, exp_item.last, ch, last);
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [2:0]  operation = 3'd0;
  logic [15:0] value     = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  character;
  logic        last;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  ascii_scoreboard sb = new();

  number_to_ascii_formatter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .operation_i (operation),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .character_o (character),
    .last_o      (last)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_n <= 1'b1;
  end

  // receiver side
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_n && out_valid && !out_stall) sb.check_result(character, last);
      @(negedge clk_i);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic drive_request(input logic [2:0] op, input logic [15:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    operation <= op;
    value     <= val;
    do @(posedge clk_i); while (in_stall);
    sb.note_request(op, val);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic random_requests(input int count);
    logic [15:0] boundaries[10] = '{16'd0, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999,
                                    16'd1000, 16'd9999, 16'd10000, 16'hFFFF};
    logic [2:0]  op;
    logic [15:0] val;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 5) op = 3'($urandom_range(OpUndefFirst, OpUndefLast));
      else op = 3'($urandom_range(nafmt_pkg::OpDecimal, nafmt_pkg::OpCrLf));
      case ($urandom_range(2))
        0:       val = 16'($urandom);
        1:       val = 16'($urandom) >> $urandom_range(15);
        default: val = boundaries[$urandom_range(9)];
      endcase
      drive_request(op, val);
    end
  endtask

  initial begin
    wait (rst_n === 1'b1);
    @(negedge clk_i);

    send_idle_pct  = 14;
    recv_stall_pct = 57;
    drive_request(nafmt_pkg::OpDecimal, 16'd0);
    drive_request(nafmt_pkg::OpDecimal, 16'd9);
    drive_request(nafmt_pkg::OpDecimal, 16'd10);
    drive_request(nafmt_pkg::OpDecimal, 16'd99);
    drive_request(nafmt_pkg::OpDecimal, 16'd1000);
    drive_request(nafmt_pkg::OpDecimal, 16'd10000);
    drive_request(nafmt_pkg::OpDecimal, 16'd10305);
    drive_request(nafmt_pkg::OpDecimal, 16'hFFFF);
    drive_request(nafmt_pkg::OpHexByte, 16'h0000);
    drive_request(nafmt_pkg::OpHexByte, 16'hFFAB);
    drive_request(nafmt_pkg::OpHexByte, 16'h12F9);
    drive_request(nafmt_pkg::OpHexWord, 16'h0000);
    drive_request(nafmt_pkg::OpHexWord, 16'hFFFF);
    drive_request(nafmt_pkg::OpHexWord, 16'h89AB);
    drive_request(nafmt_pkg::OpHexWord, 16'h1CDE);
    drive_request(nafmt_pkg::OpBinByte, 16'h0000);
    drive_request(nafmt_pkg::OpBinByte, 16'h00FF);
    drive_request(nafmt_pkg::OpBinByte, 16'h5AA5);
    drive_request(nafmt_pkg::OpCrLf, 16'h0000);
    drive_request(nafmt_pkg::OpCrLf, 16'hFFFF);
    drive_request(OpUndefFirst, 16'h1234);
    drive_request(OpUndefMid, 16'hFFFF);
    drive_request(OpUndefLast, 16'h0000);
    drive_request(nafmt_pkg::OpDecimal, 16'd7);
    random_requests(85);
    wait_drained();

    send_idle_pct  = 57;
    recv_stall_pct = 14;
    random_requests(85);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_requests(80);
    wait_drained();

    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
